// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker in sdv_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Consequent must hold in the cycle after the antecedent.
`define SDV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");
// Consequent must hold in the same cycle as the antecedent.
`define SDV_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");
`endif

// ===== hw/rtl/sdv_pkg.sv =====
// Types, constants and helper functions of the 3D stencil divergence block.
package sdv_pkg;

  localparam int POS_BITS_DEF  = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int CELLS  = 27;
  localparam int IDX_W  = 5;
  localparam int CFG_W  = 32;
  localparam int OUT_W  = 32;
  localparam int WIDE_W = 64;
  localparam int EXT_W  = 72;
  localparam int CNT_W  = 4;
  localparam int DEN_W  = 5;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [1:0]       ofs_t;

  localparam ofs_t OFS_LO  = 2'd0;
  localparam ofs_t OFS_MID = 2'd1;
  localparam ofs_t OFS_HI  = 2'd2;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_e;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SETUP,
    ST_READ,
    ST_PAIR,
    ST_DIV_INIT,
    ST_DIVIDE,
    ST_COMBINE,
    ST_MAG,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_PROD,
    ST_EMIT
  } state_e;

  // Cell index 9*a+3*b+c; t runs along the axis, u and v across it.
  function automatic idx_t cell_of(axis_e axis, ofs_t t, ofs_t u, ofs_t v);
    idx_t t5;
    idx_t u5;
    idx_t v5;
    idx_t res;
    t5 = {3'b000, t};
    u5 = {3'b000, u};
    v5 = {3'b000, v};
    unique case (axis)
      AXIS_X:  res = 5'(t5 * 5'd9) + 5'(u5 * 5'd3) + v5;
      AXIS_Y:  res = 5'(u5 * 5'd9) + 5'(t5 * 5'd3) + v5;
      AXIS_Z:  res = 5'(u5 * 5'd9) + 5'(v5 * 5'd3) + t5;
      default: res = '0;
    endcase
    return res;
  endfunction

  // Clamp a wide signed value to the signed 64-bit range.
  function automatic logic signed [WIDE_W-1:0] sat_wide(logic signed [EXT_W-1:0] x);
    logic [EXT_W-WIDE_W:0] top;
    logic signed [WIDE_W-1:0] res;
    top = x[EXT_W-1:WIDE_W-1];
    if (top == '0 || top == '1) begin
      res = x[WIDE_W-1:0];
    end else if (x[EXT_W-1]) begin
      res = {1'b1, {(WIDE_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(WIDE_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/sdv_if.sv =====
// Stream interfaces for the stencil divergence cell and result channels.
interface sdv_in_if #(
  parameter int POS_BITS = sdv_pkg::POS_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic [sdv_pkg::IDX_W-1:0]     neighbor_index;
  logic                          present;
  logic signed [POS_BITS-1:0]    pos_x;
  logic signed [POS_BITS-1:0]    pos_y;
  logic signed [POS_BITS-1:0]    pos_z;
  logic                          last_neighbor;

  modport source (
    output valid, neighbor_index, present, pos_x, pos_y, pos_z, last_neighbor,
    input  ready
  );
  modport sink (
    input  valid, neighbor_index, present, pos_x, pos_y, pos_z, last_neighbor,
    output ready
  );
endinterface

interface sdv_out_if ();
  logic                            valid;
  logic                            ready;
  logic signed [sdv_pkg::OUT_W-1:0] divergence;
  logic                            degenerate;

  modport source (output valid, divergence, degenerate, input ready);
  modport sink (input valid, divergence, degenerate, output ready);
endinterface

// ===== hw/rtl/stencil_divergence_3d.sv =====
// Top level of the 3D stencil divergence block: cell store and sequenced datapath.
//
//   channel   dir   handshake       payload
//   in_i      in    valid / ready   neighbor_index, present, pos_x/y/z, last_neighbor
//   out_o     out   valid / ready   divergence, degenerate
//   cfg       in    cfg_we_i        cfg_wdata_i (inverse_spacing)
//
// Cells load at one per cycle while in_i.ready is high. The sequencer then steps
// through the X, Y and Z axes and scales the result; the one-bit-per-cycle divider
// over ACC_W = min(POS_BITS + 5, 64) bits dominates and is skipped on pairless axes.
// in_i.ready is low while computing; a waiting result holds only the final step.
// Reset clears the presence map, the sequencer and loads inverse_spacing = 1.0.
module stencil_divergence_3d #(
  parameter int POS_BITS  = sdv_pkg::POS_BITS_DEF,
  parameter int FRAC_BITS = sdv_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [sdv_pkg::CFG_W-1:0] cfg_wdata_i,
  sdv_in_if.sink                    in_i,
  sdv_out_if.source                 out_o
);
  import sdv_pkg::*;

  localparam int ACC_W  = (POS_BITS + 5 > WIDE_W) ? WIDE_W : POS_BITS + 5;
  localparam int TOT_W  = (ACC_W + 2 > WIDE_W) ? WIDE_W : ACC_W + 2;
  localparam int STEP_W = $clog2(ACC_W);
  localparam int PROD_W = WIDE_W + CFG_W;
  localparam int MEM_W  = 3 * POS_BITS;

  state_e                   state_q, state_d;
  axis_e                    axis_q, axis_d;
  ofs_t                     lo_q, lo_d, hi_q, hi_d, u_q, u_d, v_q, v_d;
  logic                     central_q, central_d;
  logic                     pair_ok_q, pair_ok_d;
  logic [CFG_W-1:0]         inv_q;
  logic [CELLS-1:0]         pres_q, pres_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [DEN_W-1:0]         den_q, den_d;
  logic [DEN_W-1:0]         rem_q, rem_d;
  logic [ACC_W-1:0]         quo_q, quo_d;
  logic [STEP_W-1:0]        step_q, step_d;
  logic                     neg_q, neg_d;
  logic signed [TOT_W-1:0]  total_q, total_d;
  logic                     none_q, none_d;
  logic [WIDE_W-1:0]        mag_q, mag_d;
  logic [WIDE_W-1:0]        mul_q, mul_d;
  logic [PROD_W-1:0]        prod_q, prod_d;
  logic                     out_valid_q, out_valid_d;
  logic [OUT_W-1:0]         out_div_q, out_div_d;
  logic                     out_deg_q, out_deg_d;

  logic [MEM_W-1:0]         mem [CELLS];
  logic [MEM_W-1:0]         rd_a_q, rd_b_q;
  idx_t                     raddr_a, raddr_b;

  logic                     in_ready, in_fire, out_free;
  logic signed [POS_BITS-1:0] a_s, b_s;
  logic signed [EXT_W-1:0]  a_x, b_x, acc_x, diff_x, sum_x, tot_x, quo_x, deriv_x;
  logic signed [EXT_W-1:0]  acc_mag_x, new_tot_x, tot_mag_x;
  logic signed [WIDE_W-1:0] diff_w, sum_w, new_tot_w;
  logic [DEN_W:0]           trial, trial_sub;
  logic [CFG_W-1:0]         mul_a;
  logic [PROD_W-1:0]        shifted, limit, clamped;
  logic [OUT_W-1:0]         mag_out;
  logic                     central_now, hi_now;

  assign in_ready   = (state_q == ST_LOAD);
  assign in_i.ready = in_ready;
  assign in_fire    = in_i.valid && in_ready;
  assign out_free   = !out_valid_q || out_o.ready;

  assign out_o.valid      = out_valid_q;
  assign out_o.divergence = out_div_q;
  assign out_o.degenerate = out_deg_q;

  assign raddr_a = cell_of(axis_q, lo_q, u_q, v_q);
  assign raddr_b = cell_of(axis_q, hi_q, u_q, v_q);

  assign central_now = pres_q[cell_of(axis_q, OFS_LO, OFS_MID, OFS_MID)] &&
                       pres_q[cell_of(axis_q, OFS_HI, OFS_MID, OFS_MID)];
  assign hi_now      = pres_q[cell_of(axis_q, OFS_HI, OFS_MID, OFS_MID)];

  always_comb begin
    unique case (axis_q)
      AXIS_X: begin
        a_s = rd_a_q[0 +: POS_BITS];
        b_s = rd_b_q[0 +: POS_BITS];
      end
      AXIS_Y: begin
        a_s = rd_a_q[POS_BITS +: POS_BITS];
        b_s = rd_b_q[POS_BITS +: POS_BITS];
      end
      default: begin
        a_s = rd_a_q[2*POS_BITS +: POS_BITS];
        b_s = rd_b_q[2*POS_BITS +: POS_BITS];
      end
    endcase
  end

  // Pair difference and running sum, saturated at 64 bits.
  assign a_x    = {{(EXT_W-POS_BITS){a_s[POS_BITS-1]}}, a_s};
  assign b_x    = {{(EXT_W-POS_BITS){b_s[POS_BITS-1]}}, b_s};
  assign diff_w = sat_wide(b_x - a_x);
  assign diff_x = {{(EXT_W-WIDE_W){diff_w[WIDE_W-1]}}, diff_w};
  assign acc_x  = {{(EXT_W-ACC_W){acc_q[ACC_W-1]}}, acc_q};
  assign sum_x  = acc_x + diff_x;
  assign sum_w  = sat_wide(sum_x);
  assign acc_mag_x = acc_q[ACC_W-1] ? -acc_x : acc_x;

  // Restoring divider step.
  assign trial     = {rem_q, quo_q[ACC_W-1]};
  assign trial_sub = trial - {1'b0, den_q};

  assign quo_x     = {{(EXT_W-ACC_W){1'b0}}, quo_q};
  assign deriv_x   = neg_q ? -quo_x : quo_x;
  assign tot_x     = {{(EXT_W-TOT_W){total_q[TOT_W-1]}}, total_q};
  assign new_tot_x = tot_x + deriv_x;
  assign new_tot_w = sat_wide(new_tot_x);
  assign tot_mag_x = total_q[TOT_W-1] ? -tot_x : tot_x;

  // Shared 32x32 multiplier, one half of the magnitude per pass.
  assign mul_a = (state_q == ST_MUL_HI) ? mag_q[WIDE_W-1:CFG_W] : mag_q[CFG_W-1:0];

  assign shifted = prod_q >> FRAC_BITS;
  assign limit   = {{(PROD_W-OUT_W){1'b0}},
                    neg_q ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}}};
  assign clamped = (shifted > limit) ? limit : shifted;
  assign mag_out = clamped[OUT_W-1:0];

  always_comb begin
    state_d     = state_q;
    axis_d      = axis_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    u_d         = u_q;
    v_d         = v_q;
    central_d   = central_q;
    pair_ok_d   = pair_ok_q;
    pres_d      = pres_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    den_d       = den_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    step_d      = step_q;
    neg_d       = neg_q;
    total_d     = total_q;
    none_d      = none_q;
    mag_d       = mag_q;
    mul_d       = mul_q;
    prod_d      = prod_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_div_d   = out_div_q;
    out_deg_d   = out_deg_q;

    unique case (state_q)
      ST_LOAD: begin
        if (in_fire) begin
          if (in_i.neighbor_index < IDX_W'(CELLS)) begin
            pres_d[in_i.neighbor_index] = in_i.present;
          end
          if (in_i.last_neighbor) begin
            axis_d  = AXIS_X;
            total_d = '0;
            none_d  = 1'b0;
            state_d = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        central_d = central_now;
        if (central_now) begin
          lo_d = OFS_LO;
          hi_d = OFS_HI;
        end else if (hi_now) begin
          lo_d = OFS_MID;
          hi_d = OFS_HI;
        end else begin
          lo_d = OFS_LO;
          hi_d = OFS_MID;
        end
        acc_d   = '0;
        cnt_d   = '0;
        u_d     = OFS_LO;
        v_d     = OFS_LO;
        state_d = ST_READ;
      end
      ST_READ: begin
        pair_ok_d = pres_q[raddr_a] && pres_q[raddr_b];
        state_d   = ST_PAIR;
      end
      ST_PAIR: begin
        if (pair_ok_q) begin
          acc_d = sum_w[ACC_W-1:0];
          cnt_d = cnt_q + 1'b1;
        end
        state_d = ST_READ;
        if (v_q == OFS_HI) begin
          v_d = OFS_LO;
          if (u_q == OFS_HI) begin
            state_d = ST_DIV_INIT;
          end else begin
            u_d = u_q + 1'b1;
          end
        end else begin
          v_d = v_q + 1'b1;
        end
      end
      ST_DIV_INIT: begin
        if (cnt_q == '0) begin
          none_d  = 1'b1;
          quo_d   = '0;
          neg_d   = 1'b0;
          state_d = ST_COMBINE;
        end else begin
          quo_d   = acc_mag_x[ACC_W-1:0];
          neg_d   = acc_q[ACC_W-1];
          rem_d   = '0;
          step_d  = '0;
          den_d   = central_q ? {cnt_q, 1'b0} : {1'b0, cnt_q};
          state_d = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (trial >= {1'b0, den_q}) begin
          rem_d = trial_sub[DEN_W-1:0];
          quo_d = {quo_q[ACC_W-2:0], 1'b1};
        end else begin
          rem_d = trial[DEN_W-1:0];
          quo_d = {quo_q[ACC_W-2:0], 1'b0};
        end
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(ACC_W - 1)) begin
          state_d = ST_COMBINE;
        end
      end
      ST_COMBINE: begin
        total_d = new_tot_w[TOT_W-1:0];
        priority if (axis_q == AXIS_X) begin
          axis_d  = AXIS_Y;
          state_d = ST_SETUP;
        end else if (axis_q == AXIS_Y) begin
          axis_d  = AXIS_Z;
          state_d = ST_SETUP;
        end else begin
          state_d = ST_MAG;
        end
      end
      ST_MAG: begin
        mag_d   = tot_mag_x[WIDE_W-1:0];
        neg_d   = total_q[TOT_W-1];
        state_d = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        mul_d   = {{(WIDE_W-CFG_W){1'b0}}, mul_a} * {{(WIDE_W-CFG_W){1'b0}}, inv_q};
        state_d = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        prod_d  = {{(PROD_W-WIDE_W){1'b0}}, mul_q};
        mul_d   = {{(WIDE_W-CFG_W){1'b0}}, mul_a} * {{(WIDE_W-CFG_W){1'b0}}, inv_q};
        state_d = ST_PROD;
      end
      ST_PROD: begin
        prod_d  = prod_q + {mul_q, {CFG_W{1'b0}}};
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_div_d   = neg_q ? -mag_out : mag_out;
          out_deg_d   = none_q;
          pres_d      = '0;
          state_d     = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      axis_q      <= AXIS_X;
      u_q         <= OFS_LO;
      v_q         <= OFS_LO;
      pres_q      <= '0;
      acc_q       <= '0;
      cnt_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      inv_q       <= CFG_W'(1) << FRAC_BITS;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      u_q         <= u_d;
      v_q         <= v_d;
      pres_q      <= pres_d;
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        inv_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    central_q <= central_d;
    pair_ok_q <= pair_ok_d;
    den_q     <= den_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    neg_q     <= neg_d;
    total_q   <= total_d;
    none_q    <= none_d;
    mag_q     <= mag_d;
    mul_q     <= mul_d;
    prod_q    <= prod_d;
    out_div_q <= out_div_d;
    out_deg_q <= out_deg_d;
  end

  // Cell position store: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (in_fire && (in_i.neighbor_index < IDX_W'(CELLS))) begin
      mem[in_i.neighbor_index] <= {in_i.pos_z, in_i.pos_y, in_i.pos_x};
    end
    rd_a_q <= mem[raddr_a];
    rd_b_q <= mem[raddr_b];
  end

endmodule

// ===== hw/rtl/sdv_chk.sv =====
// Port-level checker for the stencil divergence block, bound to the top level.
`include "assert_macros.svh"

module sdv_chk (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      in_last_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [sdv_pkg::OUT_W-1:0] out_div_i,
  input logic                      out_deg_i
);

  `SDV_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `SDV_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_div_i) && $stable(out_deg_i))
  `SDV_ASSERT_NEXT(a_busy_after_last, clk_i, rst_ni, in_valid_i && in_ready_i && in_last_i, !in_ready_i)
  `SDV_ASSERT_NEXT(a_no_early_result, clk_i, rst_ni, in_valid_i && in_ready_i && !in_last_i && !out_valid_i, !out_valid_i)

endmodule

bind stencil_divergence_3d sdv_chk u_sdv_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.last_neighbor),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_div_i   (out_o.divergence),
  .out_deg_i   (out_o.degenerate)
);
